// File: rtl/ked_pkg.sv
// Shared types, constants and key lookup functions for the terminal key decoder.
package ked_pkg;

    localparam int CSI_BYTE_LIMIT_DEF = 16;
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TIMEOUT_RESET = 8'd40;

    // Configuration register indexes
    localparam logic REG_DECODE_ENABLE = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // Input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [4:0] {
        K_CHAR   = 5'd0,
        K_ENTER  = 5'd1,
        K_TAB    = 5'd2,
        K_BKSP   = 5'd3,
        K_ESCAPE = 5'd4,
        K_UP     = 5'd5,
        K_DOWN   = 5'd6,
        K_RIGHT  = 5'd7,
        K_LEFT   = 5'd8,
        K_HOME   = 5'd9,
        K_END    = 5'd10,
        K_INSERT = 5'd11,
        K_DELETE = 5'd12,
        K_PGUP   = 5'd13,
        K_PGDN   = 5'd14,
        K_F1     = 5'd15,
        K_F2     = 5'd16,
        K_F3     = 5'd17,
        K_F4     = 5'd18,
        K_F5     = 5'd19,
        K_F6     = 5'd20,
        K_F7     = 5'd21,
        K_F8     = 5'd22,
        K_F9     = 5'd23,
        K_F10    = 5'd24,
        K_F11    = 5'd25,
        K_F12    = 5'd26,
        K_NONE   = 5'd31
    } key_t;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_ESC  = 4'b0010,
        MODE_SS3  = 4'b0100,
        MODE_CSI  = 4'b1000
    } mode_t;

    typedef struct packed {
        key_t       key;
        logic [7:0] ch;
    } result_t;

    // One queue entry: every item that yields anything yields one or two results
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic    emit;
        logic    go_esc;
        result_t res;
    } idle_res_t;

    function automatic key_t final_key(input logic [7:0] b);
        key_t k;
        case (b)
            8'h41:   k = K_UP;
            8'h42:   k = K_DOWN;
            8'h43:   k = K_RIGHT;
            8'h44:   k = K_LEFT;
            8'h48:   k = K_HOME;
            8'h46:   k = K_END;
            8'h50:   k = K_F1;
            8'h51:   k = K_F2;
            8'h52:   k = K_F3;
            8'h53:   k = K_F4;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    function automatic key_t tilde_key(input logic [7:0] v);
        key_t k;
        case (v)
            8'd1, 8'd7: k = K_HOME;
            8'd2:       k = K_INSERT;
            8'd3:       k = K_DELETE;
            8'd4, 8'd8: k = K_END;
            8'd5:       k = K_PGUP;
            8'd6:       k = K_PGDN;
            8'd11:      k = K_F1;
            8'd12:      k = K_F2;
            8'd13:      k = K_F3;
            8'd14:      k = K_F4;
            8'd15:      k = K_F5;
            8'd17:      k = K_F6;
            8'd18:      k = K_F7;
            8'd19:      k = K_F8;
            8'd20:      k = K_F9;
            8'd21:      k = K_F10;
            8'd23:      k = K_F11;
            8'd24:      k = K_F12;
            default:    k = K_NONE;
        endcase
        return k;
    endfunction

    // Byte seen outside any sequence
    function automatic idle_res_t idle_byte(input logic [7:0] b);
        idle_res_t r;
        r.emit   = 1'b1;
        r.go_esc = 1'b0;
        r.res.ch = 8'd0;
        if (b == CH_CR || b == CH_LF) begin
            r.res.key = K_ENTER;
        end else if (b == CH_TAB) begin
            r.res.key = K_TAB;
        end else if (b == CH_BS || b == CH_DEL) begin
            r.res.key = K_BKSP;
        end else if (b == CH_ESC) begin
            r.res.key = K_NONE;
            r.emit    = 1'b0;
            r.go_esc  = 1'b1;
        end else begin
            r.res.key = K_CHAR;
            r.res.ch  = b;
        end
        return r;
    endfunction

endpackage

// File: rtl/ked_front.sv
// Front end: configuration registers, sequence state machine and result classification.
module ked_front
    import ked_pkg::*;
#(
    parameter int CSI_BYTE_LIMIT = CSI_BYTE_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_fire,
    input  logic       opcode,
    input  logic [7:0] byte_value,
    output logic       push,
    output entry_t     push_data
);

    localparam int CNT_W = $clog2(CSI_BYTE_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CSI_BYTE_LIMIT);

    logic             enable_reg;
    logic [7:0]       timeout_reg;
    mode_t            mode_reg, mode_next;
    logic [7:0]       param_value_reg, param_value_next;
    logic             param_seen_reg, param_seen_next;
    logic [CNT_W-1:0] csi_count_reg, csi_count_next;
    logic [7:0]       silence_reg, silence_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DECODE_ENABLE: enable_reg  <= cfg_data[0];
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        idle_res_t        ib;
        logic [7:0]       sil_inc;
        logic [7:0]       limit;
        logic [11:0]      prod;
        logic [CNT_W-1:0] cnt_inc;
        key_t             k;

        ib       = idle_byte(byte_value);
        sil_inc  = (silence_reg == 8'hFF) ? silence_reg : silence_reg + 8'd1;
        limit    = (timeout_reg == 8'd0) ? 8'd1 : timeout_reg;
        prod     = 12'(param_value_reg) * 12'd10 + 12'(byte_value - CH_ZERO);
        cnt_inc  = csi_count_reg + CNT_W'(1);
        k        = K_NONE;

        mode_next        = mode_reg;
        param_value_next = param_value_reg;
        param_seen_next  = param_seen_reg;
        csi_count_next   = csi_count_reg;
        silence_next     = silence_reg;
        push             = 1'b0;
        push_data.two    = 1'b0;
        push_data.r0     = ib.res;
        push_data.r1     = ib.res;

        if (in_fire)
        begin
            if (!enable_reg)
            begin
                mode_next        = MODE_IDLE;
                param_value_next = 8'd0;
                param_seen_next  = 1'b0;
                csi_count_next   = '0;
                silence_next     = 8'd0;
            end
            else if (opcode == OP_TICK)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    silence_next = sil_inc;
                    if (sil_inc >= limit)
                    begin
                        // silence inside a sequence resolves to Escape
                        mode_next        = MODE_IDLE;
                        param_value_next = 8'd0;
                        param_seen_next  = 1'b0;
                        csi_count_next   = '0;
                        silence_next     = 8'd0;
                        push             = 1'b1;
                        push_data.r0     = '{key: K_ESCAPE, ch: 8'd0};
                    end
                end
            end
            else
            begin
                case (mode_reg)
                    MODE_IDLE:
                    begin
                        push         = ib.emit;
                        silence_next = 8'd0;
                        if (ib.go_esc)
                            mode_next = MODE_ESC;
                    end
                    MODE_ESC:
                    begin
                        silence_next = 8'd0;
                        if (byte_value == CH_LBRK)
                        begin
                            mode_next        = MODE_CSI;
                            param_value_next = 8'd0;
                            param_seen_next  = 1'b0;
                            csi_count_next   = '0;
                        end
                        else if (byte_value == CH_O)
                        begin
                            mode_next = MODE_SS3;
                        end
                        else
                        begin
                            // emit Escape, then decode the byte as if idle
                            mode_next        = ib.go_esc ? MODE_ESC : MODE_IDLE;
                            param_value_next = 8'd0;
                            param_seen_next  = 1'b0;
                            csi_count_next   = '0;
                            push             = 1'b1;
                            push_data.two    = ib.emit;
                            push_data.r0     = '{key: K_ESCAPE, ch: 8'd0};
                        end
                    end
                    MODE_SS3:
                    begin
                        k                = final_key(byte_value);
                        mode_next        = MODE_IDLE;
                        param_value_next = 8'd0;
                        param_seen_next  = 1'b0;
                        csi_count_next   = '0;
                        silence_next     = 8'd0;
                        push             = (k != K_NONE);
                        push_data.r0     = '{key: k, ch: 8'd0};
                    end
                    MODE_CSI:
                    begin
                        silence_next = 8'd0;
                        if ((byte_value >= CH_ZERO && byte_value <= CH_NINE) ||
                            byte_value == CH_SEMI)
                        begin
                            if (byte_value == CH_SEMI)
                            begin
                                param_value_next = 8'd0;
                                param_seen_next  = 1'b0;
                            end
                            else
                            begin
                                param_value_next = (prod > 12'd255) ? 8'hFF : prod[7:0];
                                param_seen_next  = 1'b1;
                            end
                            csi_count_next = cnt_inc;
                            if (cnt_inc >= CNT_LIMIT)
                            begin
                                // drop an overlong sequence
                                mode_next        = MODE_IDLE;
                                param_value_next = 8'd0;
                                param_seen_next  = 1'b0;
                                csi_count_next   = '0;
                            end
                        end
                        else
                        begin
                            if (byte_value == CH_TILDE)
                                k = param_seen_reg ? tilde_key(param_value_reg) : K_NONE;
                            else
                                k = final_key(byte_value);
                            mode_next        = MODE_IDLE;
                            param_value_next = 8'd0;
                            param_seen_next  = 1'b0;
                            csi_count_next   = '0;
                            push             = (k != K_NONE);
                            push_data.r0     = '{key: k, ch: 8'd0};
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_IDLE;
            param_value_reg <= 8'd0;
            param_seen_reg  <= 1'b0;
            csi_count_reg   <= '0;
            silence_reg     <= 8'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            param_value_reg <= param_value_next;
            param_seen_reg  <= param_seen_next;
            csi_count_reg   <= csi_count_next;
            silence_reg     <= silence_next;
        end
    end

`ifndef SYNTHESIS
    a_disabled_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_fire && !enable_reg) |-> (mode_reg == MODE_IDLE && !push))
        else $error("decoder not idle after a discarded item");

    a_param_clear_outside_csi: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_CSI) |->
            (param_value_reg == 8'd0 && !param_seen_reg && csi_count_reg == '0))
        else $error("parameter state left over outside a CSI sequence");

    a_idle_no_silence: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDLE) |-> (silence_reg == 8'd0))
        else $error("silence count running while idle");
`endif

endmodule

// File: rtl/ked_queue.sv
// Short queue of classified result entries between the front and back ends.
module ked_queue
    import ked_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   empty,
    output entry_t head
);

    entry_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            count_reg <= count_reg + QUEUE_CNT_W'(push && !full)
                                   - QUEUE_CNT_W'(pop && !empty);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> !empty)
        else $error("pushed entry lost");
`endif

endmodule

// File: rtl/ked_back.sv
// Back end: unpacks queue entries into single results behind an output register.
module ked_back
    import ked_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  entry_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] key_code,
    output logic [7:0] char_value,
    output logic       last
);

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    out_last_reg;
    logic    pend_valid_reg;
    result_t pend_res_reg;
    logic    load;

    assign load = !out_valid_reg || out_ready;
    assign pop  = load && !pend_valid_reg && !empty;

    assign out_valid  = out_valid_reg;
    assign key_code   = out_res_reg.key;
    assign char_value = out_res_reg.ch;
    assign last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= !empty;
                pend_valid_reg <= !empty && head.two;
            end
        end
    end

    // Payload: second result of a pair waits in the pending slot
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_res_reg  <= pend_res_reg;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_res_reg  <= head.r0;
                out_last_reg <= !head.two;
                pend_res_reg <= head.r1;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("pending result without a shown result");

    a_first_has_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> pend_valid_reg)
        else $error("non-final result with no follower");

    a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && load) |=> (out_valid_reg && out_last_reg))
        else $error("second result not marked final");
`endif

endmodule

// File: rtl/terminal_key_escape_decoder.sv
// Results pass through the result queue and then the output register to the outputs.
// Throughput: one item per cycle while the queue is not full; two results leave in turn.
// A four-entry result queue between the state machine and the output register absorbs bursts.
// The sequence state machine advances in the cycle of acceptance, so the next item may follow.
// Reset: asynchronous, active low; decoding disabled, timeout 40 ticks, decoder idle.
module terminal_key_escape_decoder
    import ked_pkg::*;
#(
    parameter int CSI_BYTE_LIMIT = CSI_BYTE_LIMIT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] key_code,
    output logic [7:0] char_value,
    output logic       last
);

    logic   in_fire;
    logic   push;
    entry_t push_data;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t head;

    assign in_ready = !full;
    assign in_fire  = in_valid && !full;

    ked_front #(
        .CSI_BYTE_LIMIT(CSI_BYTE_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .opcode     (opcode),
        .byte_value (byte_value),
        .push       (push),
        .push_data  (push_data)
    );

    ked_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .empty     (empty),
        .head      (head)
    );

    ked_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_code   (key_code),
        .char_value (char_value),
        .last       (last)
    );

endmodule

// File: tb/sv/ked_key_event_check.sv
// Key event checker: tracks the decoder's state, predicts key events and compares them.
`timescale 1ns / 100ps
module ked_key_event_check
    import ked_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic       opcode,
    input  logic [7:0] byte_value,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [4:0] key_code,
    input  logic [7:0] char_value,
    input  logic       last,
    output int         fail_count,
    output int         pending
);

    typedef struct packed {
        key_t       key;
        logic [7:0] ch;
        logic       last;
    } key_event_t;

    key_event_t expected_keys[$];
    key_event_t staged[$];

    logic       decode_on;
    logic [7:0] silence_limit;
    mode_t      mode;
    logic [7:0] param;
    logic       param_valid;
    logic [4:0] csi_count;
    logic [7:0] silence;
    int         errors;

    function automatic key_t letter_key(input logic [7:0] b);
        case (b)
            "A":     return K_UP;
            "B":     return K_DOWN;
            "C":     return K_RIGHT;
            "D":     return K_LEFT;
            "H":     return K_HOME;
            "F":     return K_END;
            "P":     return K_F1;
            "Q":     return K_F2;
            "R":     return K_F3;
            "S":     return K_F4;
            default: return K_NONE;
        endcase
    endfunction

    function automatic key_t numbered_key(input logic [7:0] v);
        case (v)
            8'd1, 8'd7: return K_HOME;
            8'd2:       return K_INSERT;
            8'd3:       return K_DELETE;
            8'd4, 8'd8: return K_END;
            8'd5:       return K_PGUP;
            8'd6:       return K_PGDN;
            8'd11:      return K_F1;
            8'd12:      return K_F2;
            8'd13:      return K_F3;
            8'd14:      return K_F4;
            8'd15:      return K_F5;
            8'd17:      return K_F6;
            8'd18:      return K_F7;
            8'd19:      return K_F8;
            8'd20:      return K_F9;
            8'd21:      return K_F10;
            8'd23:      return K_F11;
            8'd24:      return K_F12;
            default:    return K_NONE;
        endcase
    endfunction

    function automatic void emit(input key_t k, input logic [7:0] c);
        key_event_t ev;
        ev.key  = k;
        ev.ch   = (k == K_CHAR) ? c : 8'd0;
        ev.last = 1'b0;
        staged.push_back(ev);
    endfunction

    function automatic void go_idle();
        mode        = MODE_IDLE;
        param       = 8'd0;
        param_valid = 1'b0;
        csi_count   = 5'd0;
        silence     = 8'd0;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == CH_CR || b == CH_LF)
            emit(K_ENTER, 8'd0);
        else if (b == CH_TAB)
            emit(K_TAB, 8'd0);
        else if (b == CH_BS || b == CH_DEL)
            emit(K_BKSP, 8'd0);
        else if (b == CH_ESC)
        begin
            mode    = MODE_ESC;
            silence = 8'd0;
        end
        else
            emit(K_CHAR, b);
    endfunction

    function automatic void predict_keys(input logic op, input logic [7:0] b);
        key_t       k;
        int         acc;
        logic [7:0] limit;
        staged.delete();
        if (!decode_on)
        begin
            go_idle();
            return;
        end
        if (op == OP_TICK)
        begin
            if (mode != MODE_IDLE)
            begin
                limit = (silence_limit == 8'd0) ? 8'd1 : silence_limit;
                if (silence < 8'd255)
                    silence = silence + 8'd1;
                if (silence >= limit)
                begin
                    go_idle();
                    emit(K_ESCAPE, 8'd0);
                end
            end
        end
        else if (mode == MODE_IDLE)
            plain_byte(b);
        else if (mode == MODE_ESC)
        begin
            silence = 8'd0;
            if (b == CH_LBRK)
            begin
                mode        = MODE_CSI;
                param       = 8'd0;
                param_valid = 1'b0;
                csi_count   = 5'd0;
            end
            else if (b == CH_O)
                mode = MODE_SS3;
            else
            begin
                // lone escape, then decode the byte afresh
                go_idle();
                emit(K_ESCAPE, 8'd0);
                plain_byte(b);
            end
        end
        else if (mode == MODE_SS3)
        begin
            k = letter_key(b);
            go_idle();
            if (k != K_NONE)
                emit(k, 8'd0);
        end
        else
        begin
            silence = 8'd0;
            if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI)
            begin
                if (b == CH_SEMI)
                begin
                    param       = 8'd0;
                    param_valid = 1'b0;
                end
                else
                begin
                    acc         = int'(param) * 10 + int'(b) - int'(CH_ZERO);
                    param       = (acc > 255) ? 8'd255 : acc[7:0];
                    param_valid = 1'b1;
                end
                csi_count = csi_count + 5'd1;
                // drop an overlong sequence
                if (csi_count >= CSI_BYTE_LIMIT_DEF)
                    go_idle();
            end
            else
            begin
                if (b == CH_TILDE)
                    k = param_valid ? numbered_key(param) : K_NONE;
                else
                    k = letter_key(b);
                go_idle();
                if (k != K_NONE)
                    emit(k, 8'd0);
            end
        end
        if (staged.size() > 0)
            staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i])
            expected_keys.push_back(staged[i]);
    endfunction

    function automatic void report(input string what, input key_event_t want);
        if (errors < 10)
            $display("%0t: %s: expected key %0d char %0d last %0d, got key %0d char %0d last %0d",
                     $time, what, want.key, want.ch, want.last, key_code, char_value, last);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_event_t want;
        if (!rst_n)
        begin
            decode_on     = 1'b0;
            silence_limit = TIMEOUT_RESET;
            go_idle();
            expected_keys.delete();
            errors        = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_DECODE_ENABLE)
                    decode_on = cfg_data[0];
                else
                    silence_limit = cfg_data;
            end
            // retire the oldest expectation before adding new ones
            if (out_valid && out_ready)
            begin
                if (expected_keys.size() == 0)
                begin
                    want = '0;
                    report("unexpected key event", want);
                end
                else
                begin
                    want = expected_keys.pop_front();
                    if (key_code !== want.key || char_value !== want.ch || last !== want.last)
                        report("key event mismatch", want);
                end
            end
            if (in_valid && in_ready)
                predict_keys(opcode, byte_value);
            pending    <= expected_keys.size();
            fail_count <= errors;
        end
    end

endmodule

// File: tb/sv/terminal_key_escape_decoder_tb.sv
// Top of the key decoder testbench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 100ps
module terminal_key_escape_decoder_tb
    import ked_pkg::*;
();

    localparam int NO_ACCEPT_LIMIT = 3000;
    localparam int DRAIN_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 200;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       cfg_write  = 1'b0;
    logic       cfg_index  = REG_DECODE_ENABLE;
    logic [7:0] cfg_data   = 8'd0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic       opcode     = OP_BYTE;
    logic [7:0] byte_value = 8'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [4:0] key_code;
    logic [7:0] char_value;
    logic       last;

    int   fail_count;
    int   pending;
    int   items_sent    = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   quiet_cycles  = 0;
    logic hold_req      = 1'b0;
    logic hold_taken    = 1'b0;

    string finals = "ABCDHFPQRS";
    int    tilde_params[18] = '{1, 2, 3, 4, 5, 6, 7, 8, 11, 12, 13, 14, 15, 17, 18, 19, 20,
                                23};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    terminal_key_escape_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_code   (key_code),
        .char_value (char_value),
        .last       (last)
    );

    ked_key_event_check key_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_code   (key_code),
        .char_value (char_value),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= NO_ACCEPT_LIMIT)
        begin
            $display("** terminal_key_escape_decoder: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        byte_value <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_BYTE, b);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Byte inside a sequence, now and then preceded by a stray tick
    task automatic send_seq_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 6)
            send_tick();
        send_byte(b);
    endtask

    task automatic send_number(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            send_seq_byte(s[i]);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every expected event has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_sequence(input int tmo);
        int         kind;
        int         groups;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            case ($urandom_range(0, 7))
                0:       b = CH_CR;
                1:       b = CH_LF;
                2:       b = CH_TAB;
                3:       b = ($urandom_range(0, 1) == 1) ? CH_BS : CH_DEL;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b);
        end
        else if (kind < 35)
            send_tick();
        else if (kind < 50)
        begin
            send_byte(CH_ESC);
            send_seq_byte(CH_O);
            if ($urandom_range(0, 99) < 80)
                send_seq_byte(finals[$urandom_range(0, 9)]);
            else
                send_seq_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 75)
        begin
            send_byte(CH_ESC);
            send_seq_byte(CH_LBRK);
            groups = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++)
            begin
                if (g > 0)
                    send_seq_byte(CH_SEMI);
                if ($urandom_range(0, 99) < 70)
                    send_number(tilde_params[$urandom_range(0, 17)]);
                else
                    send_number($urandom_range(0, 999));
            end
            n = $urandom_range(0, 99);
            if (n < 60)
                send_seq_byte(CH_TILDE);
            else if (n < 85)
                send_seq_byte(finals[$urandom_range(0, 9)]);
            else
                send_seq_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 80)
        begin
            send_byte(CH_ESC);
            send_seq_byte(CH_LBRK);
            n = $urandom_range(15, 18);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 10) == 10)
                    send_seq_byte(CH_SEMI);
                else
                    send_seq_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            send_seq_byte(CH_TILDE);
        end
        else if (kind < 85)
        begin
            // parameter past 255 saturates
            send_byte(CH_ESC);
            send_seq_byte(CH_LBRK);
            send_number($urandom_range(256, 99999));
            send_seq_byte(CH_TILDE);
        end
        else if (kind < 92)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_LBRK || b == CH_O);
            send_byte(CH_ESC);
            send_byte(b);
        end
        else
        begin
            send_byte(CH_ESC);
            if ($urandom_range(0, 1) == 1)
            begin
                send_byte(CH_LBRK);
                send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            n = (tmo <= 40) ? tmo : $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                send_tick();
        end
    endtask

    task automatic run_phase(input logic enable, input logic [7:0] tmo, input int idle_pct,
                             input int stall, input int count);
        int target;
        write_reg(REG_DECODE_ENABLE, {7'd0, enable});
        write_reg(REG_TIMEOUT_TICKS, tmo);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        target        = items_sent + count;
        while (items_sent < target)
            send_random_sequence(int'(tmo));
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // still disabled after reset: these are dropped
        send_byte("A");
        send_byte(CH_ESC);
        wait_drained();

        write_reg(REG_DECODE_ENABLE, 8'd1);
        write_reg(REG_TIMEOUT_TICKS, 8'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_DEL);
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        send_byte("A");
        send_byte(CH_ESC);
        send_byte(CH_O);
        send_byte("P");
        send_byte(CH_ESC);
        send_byte(CH_LBRK);
        send_byte("2");
        send_byte("4");
        send_byte(CH_TILDE);
        // escape then a plain byte gives two events
        send_byte(CH_ESC);
        send_byte("x");
        // silence inside a sequence resolves to escape
        send_byte(CH_ESC);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        wait_drained();

        run_phase(1'b1, 8'd255, 0, 0, 220);
        run_phase(1'b1, 8'd1, 71, 0, 220);
        run_phase(1'b1, 8'd7, 0, 71, 220);
        run_phase(1'b1, 8'd40, 23, 23, 220);
        run_phase(1'b0, 8'd128, 23, 23, 30);

        hold_req <= 1'b1;
        run_phase(1'b1, 8'd2, 0, 0, 220);

        if (fail_count == 0)
            $display("** terminal_key_escape_decoder: PASSED **");
        else
            $display("** terminal_key_escape_decoder: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ked_pkg.sv
rtl/ked_front.sv
rtl/ked_queue.sv
rtl/ked_back.sv
rtl/terminal_key_escape_decoder.sv
tb/sv/ked_key_event_check.sv
tb/sv/terminal_key_escape_decoder_tb.sv
